// ----- design/mcgw_pkg.sv -----
package mcgw_pkg;

  localparam logic [1:0] REQ_NOTE_ON = 2'd0;
  localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
  localparam logic [1:0] REQ_CONTROL = 2'd2;
  localparam logic [1:0] REQ_ADVANCE = 2'd3;

  localparam logic [6:0] SUSTAIN_CTRL = 7'd64;
  localparam logic [6:0] DEFAULT_VEL = 7'd80;
  localparam logic [23:0] GRACE_RESET = 24'd50000;
  localparam int unsigned TIME_W = 48;

  typedef struct packed {
    logic held;
    logic sus;
    logic [6:0] vel;
  } key_cell_t;

  typedef struct packed {
    logic rotate;
    logic release_sus;
    logic wr_held;
    logic wr_sus;
    logic wr_vel_en;
    logic [6:0] wr_vel;
  } cell_ctrl_t;

  typedef struct packed {
    logic step;
    logic finish;
    logic [6:0] pitch;
  } pack_ctrl_t;

endpackage

// ----- design/mcgw_cell.sv -----
module mcgw_cell
  import mcgw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  logic       sel,
  input  key_cell_t  nb,
  output key_cell_t  st
);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (ctrl.rotate) begin
      st <= nb;
    end else begin
      if (ctrl.release_sus && st.sus && !st.held) begin
        st.sus <= 1'b0;
      end
      if (sel) begin
        st.held <= ctrl.wr_held;
        st.sus <= ctrl.wr_sus;
        if (ctrl.wr_vel_en) begin
          st.vel <= ctrl.wr_vel;
        end
      end
    end
  end

endmodule

// ----- design/mcgw_pack.sv -----
module mcgw_pack
  import mcgw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  pack_ctrl_t        ctrl,
  input  key_cell_t         head,
  input  logic [TIME_W-1:0] now_us,
  output logic              ready,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [79:0]       m_axis_tdata,
  output logic              m_axis_tlast
);

  logic [6:0] p0_pitch, p0_vel, p1_pitch, p1_vel;
  logic p0_valid, p1_valid;
  logic [1:0] nslots;
  logic last_ne;
  logic [6:0] note_vel;
  logic note;
  logic emit;

  logic [6:0] o0_pitch, o0_vel, o1_pitch, o1_vel;
  logic o0_valid, o1_valid;
  logic [TIME_W-1:0] o_time;

  assign ready = !m_axis_tvalid || m_axis_tready;
  assign note = ctrl.step && (head.held || head.sus);
  assign note_vel = (head.vel == 7'd0) ? DEFAULT_VEL : head.vel;
  assign emit = (note && (nslots == 2'd2)) || (ctrl.finish && ((nslots != 2'd0) || last_ne));

  assign m_axis_tdata = {2'b00, o_time, o1_valid, o1_vel, o1_pitch, o0_valid, o0_vel, o0_pitch};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      m_axis_tlast <= 1'b0;
      nslots <= 2'd0;
      last_ne <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && !emit) begin
        m_axis_tvalid <= 1'b0;
      end
      if (note) begin
        if (nslots == 2'd2) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tlast <= 1'b0;
          {o0_pitch, o0_vel, o0_valid} <= {p0_pitch, p0_vel, p0_valid};
          {o1_pitch, o1_vel, o1_valid} <= {p1_pitch, p1_vel, p1_valid};
          o_time <= now_us;
          {p0_pitch, p0_vel, p0_valid} <= {ctrl.pitch, note_vel, 1'b1};
          {p1_pitch, p1_vel, p1_valid} <= '0;
          nslots <= 2'd1;
        end else if (nslots == 2'd1) begin
          {p1_pitch, p1_vel, p1_valid} <= {ctrl.pitch, note_vel, 1'b1};
          nslots <= 2'd2;
        end else begin
          {p0_pitch, p0_vel, p0_valid} <= {ctrl.pitch, note_vel, 1'b1};
          {p1_pitch, p1_vel, p1_valid} <= '0;
          nslots <= 2'd1;
        end
      end
      if (ctrl.finish) begin
        if (nslots != 2'd0) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tlast <= 1'b1;
          {o0_pitch, o0_vel, o0_valid} <= {p0_pitch, p0_vel, p0_valid};
          {o1_pitch, o1_vel, o1_valid} <= {p1_pitch, p1_vel, p1_valid};
          o_time <= now_us;
        end else if (last_ne) begin
          m_axis_tvalid <= 1'b1;
          m_axis_tlast <= 1'b1;
          {o0_pitch, o0_vel, o0_valid} <= '0;
          {o1_pitch, o1_vel, o1_valid} <= '0;
          o_time <= now_us;
        end
        last_ne <= (nslots != 2'd0);
        nslots <= 2'd0;
      end
    end
  end

endmodule

// ----- design/midi_chord_grace_window_unit.sv -----
// Chord detector for a MIDI event stream with a grace window.
// Input beats arrive on the s_axis channel: tuser carries the request type
// (note on, note off, controller, time advance), tdata the key or controller
// number, the level and a 48-bit time in microseconds. Every accepted beat
// passes through three steps: capture, time update, state update. When a chord
// is dispatched, the row of key cells rotates once through the head cell, one
// key per cycle while the output is not stalled, followed by a final flush
// step. The input is not ready again until that scan is done.
// Results leave on the m_axis channel, two note slots per beat, ascending in
// pitch, with tlast on the final beat of a chord. The output register lets
// the next input beat be accepted while a result waits. When the receiver
// stalls, the scan holds in place and resumes when the result is taken.
// cfg_we writes the grace period in microseconds at any idle time.
// Reset is synchronous and clears all key flags, velocities, the pedal,
// the window and the clock; the grace period returns to 50000.
module midi_chord_grace_window_unit
  import mcgw_pkg::*;
#(
  parameter int NUM_KEYS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // key_or_controller, level, time_us
  input  logic [63:0] s_axis_tdata,
  // req_type
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // first_pitch, first_velocity, first_valid, second_pitch, second_velocity,
  // second_valid, chord_time_us
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam int KW = $clog2(NUM_KEYS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TIME = 3'd1;
  localparam logic [2:0] ST_APPLY = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0] state;
  logic [1:0] req;
  logic [6:0] key, lvl;
  logic [TIME_W-1:0] t_in;
  logic [TIME_W-1:0] now_us, last_arrival;
  logic [23:0] grace;
  logic pedal, window;
  logic [KW-1:0] cnt;
  logic [TIME_W:0] sum;
  logic [TIME_W-1:0] elapsed;
  logic key_ok, pack_ready, wr_en, do_scan;

  cell_ctrl_t cctrl;
  pack_ctrl_t pctrl;
  key_cell_t cells [NUM_KEYS];

  assign s_axis_tready = (state == ST_IDLE);
  assign sum = {1'b0, now_us} + {1'b0, t_in};
  assign elapsed = now_us - last_arrival;
  assign key_ok = ({1'b0, key} < 8'(NUM_KEYS));

  always_comb begin
    cctrl = '0;
    wr_en = 1'b0;
    do_scan = 1'b0;
    cctrl.rotate = (state == ST_SCAN) && pack_ready;
    if (state == ST_APPLY) begin
      case (req)
        REQ_NOTE_ON: begin
          wr_en = key_ok;
          cctrl.wr_held = 1'b1;
          cctrl.wr_vel_en = 1'b1;
          cctrl.wr_vel = lvl;
        end
        REQ_NOTE_OFF: begin
          wr_en = key_ok;
          cctrl.wr_sus = pedal;
          do_scan = key_ok && !pedal && !window;
        end
        REQ_CONTROL: begin
          if (key == SUSTAIN_CTRL && pedal && !lvl[6]) begin
            cctrl.release_sus = 1'b1;
            do_scan = !window;
          end
        end
        REQ_ADVANCE: begin
          do_scan = window && (now_us >= last_arrival) &&
                    (elapsed >= {{(TIME_W - 24){1'b0}}, grace});
        end
        default: begin
          do_scan = 1'b0;
        end
      endcase
    end
  end

  assign pctrl.step = cctrl.rotate;
  assign pctrl.finish = (state == ST_FIN) && pack_ready;
  assign pctrl.pitch = 7'(cnt);

  genvar i;
  generate
    for (i = 0; i < NUM_KEYS; i++) begin : g_cell
      mcgw_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctrl (cctrl),
        .sel  (wr_en && ({1'b0, key} == 8'(i))),
        .nb   (cells[(i + 1) % NUM_KEYS]),
        .st   (cells[i])
      );
    end
  endgenerate

  mcgw_pack u_pack (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (pctrl),
    .head          (cells[0]),
    .now_us        (now_us),
    .ready         (pack_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req <= s_axis_tuser;
      key <= s_axis_tdata[6:0];
      lvl <= s_axis_tdata[13:7];
      t_in <= s_axis_tdata[61:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      now_us <= '0;
      last_arrival <= '0;
      grace <= GRACE_RESET;
      pedal <= 1'b0;
      window <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_we) begin
        grace <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            state <= ST_TIME;
          end
        end
        ST_TIME: begin
          if (req == REQ_ADVANCE) begin
            now_us <= sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
          end else if (t_in > now_us) begin
            now_us <= t_in;
          end
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (req == REQ_NOTE_ON && key_ok) begin
            last_arrival <= now_us;
            window <= 1'b1;
          end
          if (req == REQ_CONTROL && key == SUSTAIN_CTRL) begin
            pedal <= lvl[6];
          end
          if (req == REQ_ADVANCE && do_scan) begin
            window <= 1'b0;
          end
          cnt <= '0;
          state <= do_scan ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (pack_ready) begin
            cnt <= cnt + 1'b1;
            if (cnt == KW'(NUM_KEYS - 1)) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (pack_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
